>>> rtl/resp_request_deframer_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the request deframer
// Each macro expects clk and rst_n in the scope of the module that uses it.
// ----------------------------------------------------------------------------
`ifndef RESP_REQUEST_DEFRAMER_CORE_MACROS_SVH
`define RESP_REQUEST_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RRD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rrd_pkg.sv
// ----------------------------------------------------------------------------
// rrd_pkg
// Types and constants shared by the request deframer files.
// ----------------------------------------------------------------------------
`default_nettype none

package rrd_pkg;

  localparam int BYTE_W      = 8;
  localparam int ARG_INDEX_W = 8;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  // Characters of the framing.
  localparam logic [BYTE_W-1:0] CHAR_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE   = 8'h39;

  // Number of trailing bytes after each argument's payload.
  localparam int TRAIL_LEN = 2;

  // Register index, taken from paddr[2].
  localparam logic REG_MAX_ARGS     = 1'b0;
  localparam logic REG_MAX_BULK_LEN = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    MODE_HUNT    = 3'd0,
    MODE_COUNT   = 3'd1,
    MODE_DOLLAR  = 3'd2,
    MODE_LEN     = 3'd3,
    MODE_PAYLOAD = 3'd4,
    MODE_TRAIL   = 3'd5
  } mode_t;

endpackage

`default_nettype wire

>>> rtl/rrd_stream_if.sv
// ----------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels for received bytes and for deframer results.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrd_in_if;
  import rrd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rrd_out_if;
  import rrd_pkg::*;

  logic                   valid;
  logic                   ready;
  kind_t                  kind;
  logic [BYTE_W-1:0]      data;
  logic [ARG_INDEX_W-1:0] arg_index;
  logic                   cmd_last;

  modport source (output valid, output kind, output data, output arg_index,
                  output cmd_last, input ready);
  modport sink   (input valid, input kind, input data, input arg_index,
                  input cmd_last, output ready);
endinterface

`default_nettype wire

>>> rtl/rrd_cfg_regs.sv
// ----------------------------------------------------------------------------
// rrd_cfg_regs
// APB-style register file holding the argument count and length limits.
// ----------------------------------------------------------------------------
`default_nettype none

module rrd_cfg_regs #(
  parameter int COUNT_BITS = 8,
  parameter int LEN_BITS   = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rrd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rrd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rrd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic [COUNT_BITS-1:0]          max_args,
  output logic [LEN_BITS-1:0]            max_bulk_len
);
  import rrd_pkg::*;

  logic                  wr_en;
  logic                  reg_sel;
  logic [COUNT_BITS-1:0] max_args_r;
  logic [LEN_BITS-1:0]   max_bulk_len_r;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_args_r     <= COUNT_BITS'(32'd255);
      max_bulk_len_r <= LEN_BITS'(32'd1048575);
    end else if (wr_en) begin
      case (reg_sel)
        REG_MAX_ARGS:     max_args_r     <= pwdata[COUNT_BITS-1:0];
        REG_MAX_BULK_LEN: max_bulk_len_r <= pwdata[LEN_BITS-1:0];
        default:          max_args_r     <= max_args_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MAX_ARGS:     prdata = CFG_DATA_W'(max_args_r);
      REG_MAX_BULK_LEN: prdata = CFG_DATA_W'(max_bulk_len_r);
      default:          prdata = '0;
    endcase
  end

  assign max_args     = max_args_r;
  assign max_bulk_len = max_bulk_len_r;

endmodule

`default_nettype wire

>>> rtl/rrd_parser.sv
// ----------------------------------------------------------------------------
// rrd_parser
// Input byte register, framing state machine and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "resp_request_deframer_core_macros.svh"

module rrd_parser #(
  parameter int COUNT_BITS = 8,
  parameter int LEN_BITS   = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [COUNT_BITS-1:0] max_args,
  input  logic [LEN_BITS-1:0]   max_bulk_len,
  rrd_in_if.sink                in_if,
  rrd_out_if.source             out_if
);
  import rrd_pkg::*;

  localparam int ACC_W  = LEN_BITS + 1;
  localparam int PROD_W = ACC_W + 4;
  localparam int POS_W  = COUNT_BITS + 1;
  localparam int CMP_W  = (ACC_W > COUNT_BITS) ? ACC_W : COUNT_BITS;
  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  // Input byte register.
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              adv;

  // Framing state.
  mode_t                 mode_r, mode_nxt;
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  logic                  seen_r, seen_nxt;
  logic                  ended_r, ended_nxt;
  logic                  cr_r, cr_nxt;
  logic [COUNT_BITS-1:0] total_r, total_nxt;
  logic [COUNT_BITS-1:0] pos_r, pos_nxt;
  logic [ACC_W-1:0]      left_r, left_nxt;

  // Number line helpers.
  logic              is_digit;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  acc_new;
  logic              seen_new;
  logic              ended_new;
  logic              line_closed;
  logic [ACC_W-1:0]  left_dec;
  logic [POS_W-1:0]  pos_inc;
  logic              is_last;

  // Result of the current byte.
  logic                   res_valid;
  kind_t                  res_kind;
  logic [BYTE_W-1:0]      res_data;
  logic [ARG_INDEX_W-1:0] res_idx;
  logic                   res_last;

  // Result register.
  logic                   out_valid_r;
  kind_t                  out_kind_r;
  logic [BYTE_W-1:0]      out_data_r;
  logic [ARG_INDEX_W-1:0] out_idx_r;
  logic                   out_last_r;

  assign adv         = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.valid && in_if.ready) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_byte_r <= in_if.rx_byte;
    end
  end

  // Decimal accumulation saturates at the all-ones value of the accumulator.
  assign is_digit    = (s1_byte_r >= CHAR_ZERO) && (s1_byte_r <= CHAR_NINE);
  assign prod        = PROD_W'({acc_r, 3'b000}) + PROD_W'({acc_r, 1'b0})
                     + PROD_W'(s1_byte_r[3:0]);
  assign seen_new    = seen_r || (is_digit && !ended_r);
  assign ended_new   = ended_r || !is_digit;
  assign line_closed = cr_r && (s1_byte_r == CHAR_LF);
  assign left_dec    = left_r - ACC_W'(1);
  assign pos_inc     = {1'b0, pos_r} + POS_W'(1);
  assign is_last     = pos_inc >= {1'b0, total_r};

  always_comb begin
    if (!is_digit || ended_r) begin
      acc_new = acc_r;
    end else if (prod > PROD_W'(ACC_MAX)) begin
      acc_new = ACC_MAX;
    end else begin
      acc_new = prod[ACC_W-1:0];
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    seen_nxt  = seen_r;
    ended_nxt = ended_r;
    cr_nxt    = cr_r;
    total_nxt = total_r;
    pos_nxt   = pos_r;
    left_nxt  = left_r;
    res_valid = 1'b0;
    res_kind  = KIND_DATA;
    res_data  = '0;
    res_idx   = ARG_INDEX_W'(pos_r);
    res_last  = 1'b0;
    case (mode_r)
      MODE_COUNT: begin
        acc_nxt   = acc_new;
        seen_nxt  = seen_new;
        ended_nxt = ended_new;
        cr_nxt    = (s1_byte_r == CHAR_CR);
        if (line_closed) begin
          if (!seen_new || acc_new == '0 || CMP_W'(acc_new) > CMP_W'(max_args)) begin
            mode_nxt  = MODE_HUNT;
            res_valid = 1'b1;
            res_kind  = KIND_ERR;
            res_idx   = '0;
          end else begin
            total_nxt = COUNT_BITS'(acc_new);
            pos_nxt   = '0;
            mode_nxt  = MODE_DOLLAR;
          end
        end
      end
      MODE_DOLLAR: begin
        if (s1_byte_r != CHAR_DOLLAR) begin
          mode_nxt  = MODE_HUNT;
          res_valid = 1'b1;
          res_kind  = KIND_ERR;
        end else begin
          acc_nxt   = '0;
          seen_nxt  = 1'b0;
          ended_nxt = 1'b0;
          cr_nxt    = 1'b0;
          mode_nxt  = MODE_LEN;
        end
      end
      MODE_LEN: begin
        acc_nxt   = acc_new;
        seen_nxt  = seen_new;
        ended_nxt = ended_new;
        cr_nxt    = (s1_byte_r == CHAR_CR);
        if (line_closed) begin
          if (!seen_new || acc_new > ACC_W'(max_bulk_len)) begin
            mode_nxt  = MODE_HUNT;
            res_valid = 1'b1;
            res_kind  = KIND_ERR;
          end else if (acc_new == '0) begin
            mode_nxt = MODE_TRAIL;
            left_nxt = ACC_W'(TRAIL_LEN);
          end else begin
            mode_nxt = MODE_PAYLOAD;
            left_nxt = acc_new;
          end
        end
      end
      MODE_PAYLOAD: begin
        res_valid = 1'b1;
        res_data  = s1_byte_r;
        if (left_dec == '0) begin
          mode_nxt = MODE_TRAIL;
          left_nxt = ACC_W'(TRAIL_LEN);
        end else begin
          left_nxt = left_dec;
        end
      end
      MODE_TRAIL: begin
        left_nxt = left_dec;
        if (left_dec == '0) begin
          res_valid = 1'b1;
          res_kind  = KIND_END;
          res_last  = is_last;
          pos_nxt   = pos_inc[COUNT_BITS-1:0];
          mode_nxt  = is_last ? MODE_HUNT : MODE_DOLLAR;
        end
      end
      default: begin
        mode_nxt = MODE_HUNT;
        if (s1_byte_r == CHAR_STAR) begin
          acc_nxt   = '0;
          seen_nxt  = 1'b0;
          ended_nxt = 1'b0;
          cr_nxt    = 1'b0;
          mode_nxt  = MODE_COUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_HUNT;
      acc_r   <= '0;
      seen_r  <= 1'b0;
      ended_r <= 1'b0;
      cr_r    <= 1'b0;
      total_r <= '0;
      pos_r   <= '0;
      left_r  <= '0;
    end else if (adv) begin
      mode_r  <= mode_nxt;
      acc_r   <= acc_nxt;
      seen_r  <= seen_nxt;
      ended_r <= ended_nxt;
      cr_r    <= cr_nxt;
      total_r <= total_nxt;
      pos_r   <= pos_nxt;
      left_r  <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_kind_r <= res_kind;
      out_data_r <= res_data;
      out_idx_r  <= res_idx;
      out_last_r <= res_last;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.kind      = out_kind_r;
  assign out_if.data      = out_data_r;
  assign out_if.arg_index = out_idx_r;
  assign out_if.cmd_last  = out_last_r;

  `RRD_ASSERT_NOW(a_stall_only_when_full, !in_if.ready, s1_valid_r && out_valid_r && !out_if.ready, "input stalled without a full result register")
  `RRD_ASSERT_NEXT(a_error_rehunts, adv && res_valid && res_kind == KIND_ERR, mode_r == MODE_HUNT, "framing error did not restart hunting")
  `RRD_ASSERT_NEXT(a_payload_emits, adv && mode_r == MODE_PAYLOAD, out_valid_r && out_kind_r == KIND_DATA, "payload byte produced no data word")
  `RRD_ASSERT_NOW(a_last_on_end, out_valid_r && out_last_r, out_kind_r == KIND_END, "cmd_last set on a word that is not an argument end")
  `RRD_ASSERT_NOW(a_data_zero, out_valid_r && out_kind_r != KIND_DATA, out_data_r == '0, "non-payload word carries data")

endmodule

`default_nettype wire

>>> rtl/resp_request_deframer_core.sv
// ----------------------------------------------------------------------------
// resp_request_deframer_core
// Deframes multi-bulk request arrays from a received byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes of the request stream enter on in_if (valid/ready, one word per
//   byte). Each byte yields zero or one result word on out_if: a payload
//   byte, an end of argument (with cmd_last on the final argument of a
//   command) or a framing error, after which the block hunts for '*'.
//   Each byte passes from the input byte register through the framing
//   state update into the result register; one byte is accepted every
//   cycle while out_if does not stall. When out_if stalls, the result
//   register holds its word and one further byte is taken into the input
//   register; after that in_if.ready drops until the result is taken.
//   The APB port holds max_args (offset 0) and max_bulk_len (offset 4).
//   The user must write it only while the block is idle; the block itself
//   does not enforce this. pready is always high.
//   Synchronous active-low reset returns the block to hunting, empties both
//   registers and restores the limits to 255 and 1048575.
// ----------------------------------------------------------------------------
`default_nettype none

module resp_request_deframer_core #(
  parameter int COUNT_BITS = 8,
  parameter int LEN_BITS   = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rrd_in_if.sink                         in_if,
  rrd_out_if.source                      out_if,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rrd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rrd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rrd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import rrd_pkg::*;

  logic [COUNT_BITS-1:0] max_args;
  logic [LEN_BITS-1:0]   max_bulk_len;

  rrd_cfg_regs #(
    .COUNT_BITS (COUNT_BITS),
    .LEN_BITS   (LEN_BITS)
  ) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .max_args     (max_args),
    .max_bulk_len (max_bulk_len)
  );

  rrd_parser #(
    .COUNT_BITS (COUNT_BITS),
    .LEN_BITS   (LEN_BITS)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .max_args     (max_args),
    .max_bulk_len (max_bulk_len),
    .in_if        (in_if),
    .out_if       (out_if)
  );

endmodule

`default_nettype wire

>>> tb/resp_request_deframer_core_test.sv
// ----------------------------------------------------------------------------
// Request deframer testbench
// Feeds byte streams of multi-bulk requests into resp_request_deframer_core
// and checks every result word against a cycle-free prediction of the
// deframing. Well-formed requests with random payloads make up most of the
// stream. Broken requests, line noise and several limit settings written
// over the APB port cover the error paths. Both channels stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module resp_request_deframer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rrd_pkg::*;

  localparam int COUNT_W       = 8;
  localparam int LEN_W         = 20;
  localparam int ACC_MAX       = (1 << (LEN_W + 1)) - 1;
  localparam int COUNT_TOP     = (1 << COUNT_W) - 1;
  localparam int LEN_TOP       = (1 << LEN_W) - 1;
  localparam int SETTLE_CYCLES = 6;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PRINT_CAP     = 200;
  localparam int HOLD_CYCLES   = 300;

  typedef struct packed {
    kind_t                  kind;
    logic [BYTE_W-1:0]      data;
    logic [ARG_INDEX_W-1:0] arg_index;
    logic                   cmd_last;
  } deframe_word_t;

  typedef enum int {
    FLAW_NONE,
    FLAW_COUNT_ZERO,
    FLAW_COUNT_NO_DIGITS,
    FLAW_COUNT_ABOVE,
    FLAW_NO_DOLLAR,
    FLAW_LEN_NO_DIGITS,
    FLAW_LEN_ABOVE
  } flaw_e;

  class request_scoreboard;
    mode_t              mode;
    logic [LEN_W:0]     number;
    bit                 digits_seen;
    bit                 digits_done;
    bit                 after_cr;
    logic [COUNT_W-1:0] arg_count;
    logic [COUNT_W-1:0] arg_at;
    logic [LEN_W:0]     bytes_to_go;
    logic [COUNT_W-1:0] lim_args;
    logic [LEN_W-1:0]   lim_len;
    deframe_word_t      due_words[$];
    int                 mismatches;

    function new();
      mode        = MODE_HUNT;
      number      = '0;
      digits_seen = 1'b0;
      digits_done = 1'b0;
      after_cr    = 1'b0;
      arg_count   = '0;
      arg_at      = '0;
      bytes_to_go = '0;
      lim_args    = COUNT_W'(COUNT_TOP);
      lim_len     = LEN_W'(LEN_TOP);
      mismatches  = 0;
    endfunction

    function void set_limit(logic sel, logic [CFG_DATA_W-1:0] value);
      if (sel == REG_MAX_ARGS) begin
        lim_args = value[COUNT_W-1:0];
      end else begin
        lim_len = value[LEN_W-1:0];
      end
    endfunction

    function void restart_number();
      number      = '0;
      digits_seen = 1'b0;
      digits_done = 1'b0;
      after_cr    = 1'b0;
    endfunction

    // Returns 1 when this byte is the LF of a CR LF pair closing the line.
    function bit number_line(logic [BYTE_W-1:0] b);
      bit closed;
      int d;
      closed = after_cr && (b == CHAR_LF);
      if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
        if (!digits_done) begin
          d = int'(b - CHAR_ZERO);
          if (int'(number) > (ACC_MAX - d) / 10) begin
            number = (LEN_W + 1)'(ACC_MAX);
          end else begin
            number = (LEN_W + 1)'(int'(number) * 10 + d);
          end
          digits_seen = 1'b1;
        end
      end else begin
        digits_done = 1'b1;
      end
      after_cr = (b == CHAR_CR);
      return closed;
    endfunction

    function void add_word(kind_t k, logic [BYTE_W-1:0] d, logic [ARG_INDEX_W-1:0] idx,
                           logic last);
      deframe_word_t w;
      w.kind      = k;
      w.data      = d;
      w.arg_index = idx;
      w.cmd_last  = last;
      due_words.push_back(w);
    endfunction

    function void flag_error(logic [ARG_INDEX_W-1:0] idx);
      mode = MODE_HUNT;
      add_word(KIND_ERR, '0, idx, 1'b0);
    endfunction

    function void take_byte(logic [BYTE_W-1:0] b);
      bit last_arg;
      case (mode)
        MODE_COUNT: begin
          if (number_line(b)) begin
            if (!digits_seen || number == 0 || number > lim_args) begin
              flag_error('0);
            end else begin
              arg_count = number[COUNT_W-1:0];
              arg_at    = '0;
              mode      = MODE_DOLLAR;
            end
          end
        end
        MODE_DOLLAR: begin
          if (b != CHAR_DOLLAR) begin
            flag_error(arg_at);
          end else begin
            restart_number();
            mode = MODE_LEN;
          end
        end
        MODE_LEN: begin
          if (number_line(b)) begin
            if (!digits_seen || number > lim_len) begin
              flag_error(arg_at);
            end else if (number == 0) begin
              bytes_to_go = (LEN_W + 1)'(TRAIL_LEN);
              mode        = MODE_TRAIL;
            end else begin
              bytes_to_go = number;
              mode        = MODE_PAYLOAD;
            end
          end
        end
        MODE_PAYLOAD: begin
          bytes_to_go = bytes_to_go - 1'b1;
          if (bytes_to_go == 0) begin
            mode        = MODE_TRAIL;
            bytes_to_go = (LEN_W + 1)'(TRAIL_LEN);
          end
          add_word(KIND_DATA, b, arg_at, 1'b0);
        end
        MODE_TRAIL: begin
          // The two trailing bytes are swallowed without a look at them.
          bytes_to_go = bytes_to_go - 1'b1;
          if (bytes_to_go == 0) begin
            last_arg = (int'(arg_at) + 1 >= int'(arg_count));
            add_word(KIND_END, '0, arg_at, last_arg);
            arg_at = arg_at + 1'b1;
            mode   = last_arg ? MODE_HUNT : MODE_DOLLAR;
          end
        end
        default: begin
          mode = MODE_HUNT;
          if (b == CHAR_STAR) begin
            restart_number();
            mode = MODE_COUNT;
          end
        end
      endcase
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("%0t: %s", $time, msg);
    endtask

    task check_word(deframe_word_t got);
      deframe_word_t want;
      if (due_words.size() == 0) begin
        report($sformatf("result word with nothing due: kind %0d data %h index %0d last %0b",
                         got.kind, got.data, got.arg_index, got.cmd_last));
        return;
      end
      want = due_words.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind: got %0d, want %0d", got.kind, want.kind));
      if (got.data !== want.data)
        report($sformatf("data: got %h, want %h", got.data, want.data));
      if (got.arg_index !== want.arg_index)
        report($sformatf("arg_index: got %0d, want %0d", got.arg_index, want.arg_index));
      if (got.cmd_last !== want.cmd_last)
        report($sformatf("cmd_last: got %0b, want %0b", got.cmd_last, want.cmd_last));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  rrd_in_if  in_ch ();
  rrd_out_if out_ch ();

  request_scoreboard sb = new();

  int          burst_left    = 0;
  int          gap_max       = 0;
  int          stall_style   = 0;
  int          hold_off_left = 0;
  int          sent_items    = 0;
  int          quiet_cycles  = 0;
  logic [15:0] stall_pattern;
  logic [3:0]  pat_pos;
  int          pat_age;

  resp_request_deframer_core i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.take_byte(in_ch.rx_byte);
  end

  always @(posedge clk) begin : watch_results
    deframe_word_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind      = out_ch.kind;
      got.data      = out_ch.data;
      got.arg_index = out_ch.arg_index;
      got.cmd_last  = out_ch.cmd_last;
      sb.check_word(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || psel || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: a long hold-off when one is requested, else either always
  // ready or a rolling stall pattern that is redrawn when its random age runs out.
  initial begin : result_sink
    out_ch.ready = 1'b0;
    pat_pos      = '0;
    pat_age      = 0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_off_left--;
      end else if (stall_style == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        if (pat_age == 0) begin
          if ($urandom_range(3) == 0) begin
            stall_pattern = (16'($urandom) & 16'($urandom)) | 16'h0001;
          end else begin
            stall_pattern = 16'($urandom) | 16'($urandom);
          end
          pat_age = $urandom_range(16, 96);
        end
        out_ch.ready <= stall_pattern[pat_pos];
        pat_pos++;
        pat_age--;
      end
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(gap_max);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic put(input logic [BYTE_W-1:0] b);
    sent_items++;
    send_byte(b);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  task automatic put_crlf();
    put(CHAR_CR);
    put(CHAR_LF);
  endtask

  task automatic put_line(input string s);
    put_text(s);
    put_crlf();
  endtask

  function automatic logic [BYTE_W-1:0] any_letter();
    return 8'h61 + 8'($urandom_range(25));
  endfunction

  function automatic logic [BYTE_W-1:0] any_digit();
    return CHAR_ZERO + 8'($urandom_range(9));
  endfunction

  // A number line; the fuzzy forms add leading zeros, ignored digits after a
  // letter, or a CR that is not followed by LF.
  task automatic put_number(input int unsigned v, input bit fuzzy);
    string digits;
    int    style;
    digits = $sformatf("%0d", v);
    style  = fuzzy ? $urandom_range(1, 3) : 0;
    if (style == 1) repeat ($urandom_range(1, 3)) put(CHAR_ZERO);
    put_text(digits);
    if (style == 2) begin
      put(any_letter());
      repeat ($urandom_range(1, 3)) put(any_digit());
    end
    if (style == 3) begin
      put(CHAR_CR);
      put(any_letter());
    end
    put_crlf();
  endtask

  // At least eight digits, so the value is past every limit and saturates.
  task automatic put_huge_line();
    put(CHAR_ZERO + 8'($urandom_range(1, 9)));
    repeat ($urandom_range(7, 20)) put(any_digit());
    put_crlf();
  endtask

  task automatic put_letters_line();
    repeat ($urandom_range(0, 2)) put(any_letter());
    put_crlf();
  endtask

  task automatic put_trailer();
    if ($urandom_range(3) != 0) begin
      put_crlf();
    end else begin
      put(8'($urandom));
      put(8'($urandom));
    end
  endtask

  function automatic int pick_len();
    int hi;
    hi = ($urandom_range(19) == 0) ? 40 : 8;
    if (int'(sb.lim_len) < hi) hi = int'(sb.lim_len);
    return ($urandom_range(7) == 0) ? hi : $urandom_range(hi);
  endfunction

  task automatic put_request(input flaw_e flaw);
    int                cap;
    int                argc;
    int                bad_arg;
    int                len;
    logic [BYTE_W-1:0] b;
    cap = int'(sb.lim_args);
    if (cap == 0) begin
      argc = $urandom_range(1, 3);
    end else if (cap <= 16 && $urandom_range(7) == 0) begin
      argc = cap;
    end else begin
      argc = $urandom_range(1, (cap < 4) ? cap : 4);
    end
    bad_arg = $urandom_range(argc - 1);
    put(CHAR_STAR);
    case (flaw)
      FLAW_COUNT_ZERO: begin
        put_number(0, $urandom_range(1));
        return;
      end
      FLAW_COUNT_NO_DIGITS: begin
        put_letters_line();
        return;
      end
      FLAW_COUNT_ABOVE: begin
        if ($urandom_range(1) == 0) put_huge_line();
        else put_number(cap + 1 + $urandom_range(3), $urandom_range(1));
        return;
      end
      default: put_number(argc, $urandom_range(3) == 0);
    endcase
    for (int i = 0; i < argc; i++) begin
      if (i == bad_arg && flaw == FLAW_NO_DOLLAR) begin
        do b = 8'($urandom); while (b == CHAR_DOLLAR);
        put(b);
        return;
      end
      put(CHAR_DOLLAR);
      if (i == bad_arg && flaw == FLAW_LEN_NO_DIGITS) begin
        put_letters_line();
        return;
      end
      if (i == bad_arg && flaw == FLAW_LEN_ABOVE) begin
        if ($urandom_range(1) == 0) put_huge_line();
        else put_number(int'(sb.lim_len) + 1 + $urandom_range(3), $urandom_range(1));
        return;
      end
      len = pick_len();
      put_number(len, $urandom_range(3) == 0);
      repeat (len) put(8'($urandom));
      put_trailer();
    end
  endtask

  task automatic random_requests(input int budget);
    int goal;
    int pick;
    goal = sent_items + budget;
    while (sent_items < goal) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        // Line noise, closed by CR LF so that a stray star cannot linger.
        repeat ($urandom_range(1, 6)) put(8'($urandom));
        put(CHAR_CR);
        put(CHAR_LF);
      end else if (pick < 72) begin
        put_request(FLAW_NONE);
      end else begin
        put_request(flaw_e'($urandom_range(FLAW_COUNT_ZERO, FLAW_LEN_ABOVE)));
      end
    end
  endtask

  task automatic directed_requests();
    put_line("*1");
    put_line("$3");
    put_line("abc");
    put_line("*0");
    put_line("*");
    put_line("*300");
    // The second argument's dollar is replaced by a letter.
    put_line("*2");
    put_line("$0");
    put_line("");
    put_text("X");
    put_line("*1");
    put_line("$");
    put_line("*1");
    put_line("$1048576");
    put_line("*1");
    put_line("$99999999999999999");
    put_line("*2x9");
    put_line("$1");
    put_line("Q");
    put_line("$0");
    put_text("zz");
    put_text("*1");
    put(CHAR_CR);
    put_line("z");
    put_line("$004");
    put_text("wxyz");
    put(8'hFF);
    put(8'h00);
  endtask

  // Largest count: arg_index runs up to one below its top value.
  task automatic put_widest_command();
    put(CHAR_STAR);
    put_number(COUNT_TOP, 1'b0);
    repeat (COUNT_TOP) begin
      put(CHAR_DOLLAR);
      put_number(0, 1'b0);
      put_crlf();
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.due_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic sel, input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_limit(sel, value);
    want = (sel == REG_MAX_ARGS) ? CFG_DATA_W'(sb.lim_args) : CFG_DATA_W'(sb.lim_len);
    // Read the register straight back, keeping psel high.
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      sb.report($sformatf("register %0d reads %h, want %h", sel, prdata, want));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : stimulus
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset limits.
    gap_max     = 4;
    stall_style = 1;
    directed_requests();
    random_requests(110);

    // One argument at most, only empty payloads; no idling on either side.
    settle();
    write_limit(REG_MAX_ARGS, 32'd1);
    write_limit(REG_MAX_BULK_LEN, 32'd0);
    gap_max     = 0;
    stall_style = 0;
    random_requests(50);

    // Upper register bits must be dropped.
    settle();
    write_limit(REG_MAX_ARGS, 32'hABCD_EF03);
    write_limit(REG_MAX_BULK_LEN, 32'hFFF0_0005);
    gap_max     = 8;
    stall_style = 1;
    random_requests(90);

    // A count limit of zero rejects every request.
    settle();
    write_limit(REG_MAX_ARGS, 32'h0000_0100);
    write_limit(REG_MAX_BULK_LEN, 32'd16);
    gap_max     = 2;
    stall_style = 0;
    random_requests(30);

    settle();
    write_limit(REG_MAX_ARGS, 32'(COUNT_TOP));
    write_limit(REG_MAX_BULK_LEN, 32'(LEN_TOP));
    gap_max     = 3;
    stall_style = 1;
    // A payload while results are held back, so the input side backs up.
    hold_off_left = HOLD_CYCLES;
    put(CHAR_STAR);
    put_number(1, 1'b0);
    put(CHAR_DOLLAR);
    put_number(16, 1'b0);
    repeat (16) put(8'($urandom));
    put_crlf();
    put_widest_command();
    random_requests(90);

    settle();
    write_limit(REG_MAX_ARGS, 32'($urandom_range(2, 254)));
    write_limit(REG_MAX_BULK_LEN, 32'($urandom_range(1, 100)));
    gap_max     = 0;
    stall_style = 1;
    random_requests(40);

    settle();
    if (sb.mismatches == 0 && sb.due_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
+incdir+rtl
rtl/rrd_pkg.sv
rtl/rrd_stream_if.sv
rtl/rrd_cfg_regs.sv
rtl/rrd_parser.sv
rtl/resp_request_deframer_core.sv
tb/resp_request_deframer_core_test.sv
